/* rtl/core/dtps_pkg.sv */
// Shared types, constants and helpers for the decision tree path sum classifier.
package dtps_pkg;

   // Default sizes of the tables and of the value word
   localparam int MAX_NODES_DEFAULT    = 32;
   localparam int MAX_LEAVES_DEFAULT   = 32;
   localparam int MAX_FEATURES_DEFAULT = 16;
   localparam int VALUE_BITS_DEFAULT   = 16;

   // Fixed field widths
   localparam int PATH_BITS   = 32;
   localparam int INDEX_BITS  = 5;
   localparam int FSEL_BITS   = 4;
   localparam int LABEL_BITS  = 8;
   localparam int COUNT_BITS  = 6;
   localparam int KIND_BITS   = 2;
   localparam int CSR_IDX_BITS = 2;

   // Request kinds carried in req_tuser
   localparam logic [KIND_BITS-1:0] REQ_NODE    = 2'd0;
   localparam logic [KIND_BITS-1:0] REQ_LEAF    = 2'd1;
   localparam logic [KIND_BITS-1:0] REQ_FEATURE = 2'd2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_BITS-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LEAF_COUNT = 2'd1;

   // Address width for a table of a given depth (at least one bit)
   function automatic int addr_bits(int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Smaller of two sizes
   function automatic int min_int(int a, int b);
      return (a < b) ? a : b;
   endfunction

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NODE_RUN,
      ST_LEAF_RUN,
      ST_FINISH
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;      // request beat accepted this cycle
      logic start;     // classification begins, clear working state
      logic node_run;  // node compare pass
      logic leaf_run;  // leaf scoring pass
      logic load_out;  // move best leaf into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic node_done;
      logic leaf_done;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/dtps_ram.sv */
// Generic single write port, single read port RAM with registered read.
module dtps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrBits = dtps_pkg::addr_bits(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/dtps_ctrl.sv */
// Sequencer for table loads, node compare pass, leaf scoring pass and result hand-off.
module dtps_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dtps_pkg::KIND_BITS-1:0]     req_kind,
   input  logic                               req_last,
   input  dtps_pkg::status_type               status,
   output dtps_pkg::cmd_type                  cmd
);

   dtps_pkg::ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         dtps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
            if (req_tvalid && req_kind == dtps_pkg::REQ_FEATURE && req_last) begin
               cmd.start = 1'b1;
               state_in  = dtps_pkg::ST_NODE_RUN;
            end
         end
         dtps_pkg::ST_NODE_RUN: begin
            cmd.node_run = 1'b1;
            if (status.node_done) begin
               state_in = dtps_pkg::ST_LEAF_RUN;
            end
         end
         dtps_pkg::ST_LEAF_RUN: begin
            cmd.leaf_run = 1'b1;
            if (status.leaf_done) begin
               state_in = dtps_pkg::ST_FINISH;
            end
         end
         dtps_pkg::ST_FINISH: begin
            // wait until the output register can take the result
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = dtps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/dtps_dp.sv */
// Datapath: tables, count registers, node compare pipeline, leaf scoring and output register.
module dtps_dp #(
   parameter int MAX_NODES    = dtps_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_LEAVES   = dtps_pkg::MAX_LEAVES_DEFAULT,
   parameter int MAX_FEATURES = dtps_pkg::MAX_FEATURES_DEFAULT,
   parameter int VALUE_BITS   = dtps_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dtps_pkg::cmd_type                      cmd,
   output dtps_pkg::status_type                   status,
   // request fields
   input  logic [dtps_pkg::KIND_BITS-1:0]         req_kind,
   input  logic [dtps_pkg::INDEX_BITS-1:0]        req_entry_index,
   input  logic [dtps_pkg::FSEL_BITS-1:0]         req_feature_select,
   input  logic signed [VALUE_BITS-1:0]           req_fixed_value,
   input  logic [dtps_pkg::LABEL_BITS-1:0]        req_leaf_class,
   input  logic [dtps_pkg::PATH_BITS-1:0]         req_path_members,
   input  logic [dtps_pkg::PATH_BITS-1:0]         req_path_went_left,
   // configuration writes
   input  logic                                   csr_write,
   input  logic [dtps_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [dtps_pkg::COUNT_BITS-1:0]        csr_data,
   // result register
   output logic                                   rsp_valid,
   input  logic                                   rsp_taken,
   output logic [dtps_pkg::LABEL_BITS-1:0]        rsp_predicted_class,
   output logic [dtps_pkg::INDEX_BITS-1:0]        rsp_winning_leaf,
   output logic [dtps_pkg::COUNT_BITS-1:0]        rsp_winning_score
);

   localparam int NodeDepth = dtps_pkg::min_int(MAX_NODES, dtps_pkg::PATH_BITS);
   localparam int LeafDepth = dtps_pkg::min_int(MAX_LEAVES, dtps_pkg::PATH_BITS);
   localparam int FeatDepth = dtps_pkg::min_int(MAX_FEATURES, dtps_pkg::PATH_BITS);
   localparam int NodeAw = dtps_pkg::addr_bits(NodeDepth);
   localparam int LeafAw = dtps_pkg::addr_bits(LeafDepth);
   localparam int FeatAw = dtps_pkg::addr_bits(FeatDepth);
   localparam int NodeWidth = dtps_pkg::FSEL_BITS + VALUE_BITS;
   localparam int LeafWidth = dtps_pkg::LABEL_BITS + 2 * dtps_pkg::PATH_BITS;
   localparam int CountBits = dtps_pkg::COUNT_BITS;

   // ---------------------------------------------------------------
   // Count registers
   logic [CountBits-1:0] node_count_ff, leaf_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         leaf_count_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            dtps_pkg::CSR_NODE_COUNT: node_count_ff <= csr_data;
            dtps_pkg::CSR_LEAF_COUNT: leaf_count_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // counts beyond the table size act as the table size
   logic [CountBits-1:0] nodes, leaves;
   assign nodes  = (node_count_ff > CountBits'(NodeDepth)) ? CountBits'(NodeDepth)
                                                           : node_count_ff;
   assign leaves = (leaf_count_ff > CountBits'(LeafDepth)) ? CountBits'(LeafDepth)
                                                           : leaf_count_ff;

   // ---------------------------------------------------------------
   // Table write decode
   logic [31:0] entry_wide;
   logic        node_wr, leaf_wr, feat_wr;

   assign entry_wide = 32'(req_entry_index);
   assign node_wr = cmd.take && req_kind == dtps_pkg::REQ_NODE
                    && entry_wide < 32'(MAX_NODES);
   assign leaf_wr = cmd.take && req_kind == dtps_pkg::REQ_LEAF
                    && entry_wide < 32'(MAX_LEAVES);
   assign feat_wr = cmd.take && req_kind == dtps_pkg::REQ_FEATURE
                    && entry_wide < 32'(MAX_FEATURES);

   // ---------------------------------------------------------------
   // Node compare pass: issue, node read, feature read, compare
   logic [CountBits-1:0]              node_idx_ff, node_idx_in;
   logic                              node_issue;
   logic                              s1_valid_ff;
   logic [dtps_pkg::INDEX_BITS-1:0]   s1_idx_ff;
   logic                              s2_valid_ff;
   logic [dtps_pkg::INDEX_BITS-1:0]   s2_idx_ff;
   logic                              s2_zero_ff;
   logic signed [VALUE_BITS-1:0]      s2_thr_ff;
   logic [dtps_pkg::PATH_BITS-1:0]    ind_ff, ind_in;

   logic [NodeWidth-1:0]              node_rd_data;
   logic [dtps_pkg::FSEL_BITS-1:0]    node_fsel;
   logic signed [VALUE_BITS-1:0]      node_thr;
   logic [31:0]                       fsel_wide;
   logic                              fsel_out;
   logic [VALUE_BITS-1:0]             feat_rd_data;
   logic signed [VALUE_BITS-1:0]      feat_value;

   assign node_issue  = cmd.node_run && node_idx_ff < nodes;
   assign node_idx_in = node_idx_ff + CountBits'(1);

   assign node_fsel = node_rd_data[dtps_pkg::FSEL_BITS-1:0];
   assign node_thr  = $signed(node_rd_data[NodeWidth-1:dtps_pkg::FSEL_BITS]);
   assign fsel_wide = 32'(node_fsel);
   assign fsel_out  = fsel_wide >= 32'(MAX_FEATURES);

   // a node on a feature past the store compares zero
   assign feat_value = s2_zero_ff ? '0 : $signed(feat_rd_data);

   always_comb begin
      ind_in = ind_ff;
      if (s2_valid_ff && feat_value > s2_thr_ff) begin
         ind_in[s2_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_idx_ff <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            node_idx_ff <= '0;
         end else if (node_issue) begin
            node_idx_ff <= node_idx_in;
         end
         s1_valid_ff <= node_issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff  <= node_idx_ff[dtps_pkg::INDEX_BITS-1:0];
      s2_idx_ff  <= s1_idx_ff;
      s2_zero_ff <= fsel_out;
      s2_thr_ff  <= node_thr;
      if (cmd.start) begin
         ind_ff <= '0;
      end else begin
         ind_ff <= ind_in;
      end
   end

   assign status.node_done = node_idx_ff >= nodes && !s1_valid_ff && !s2_valid_ff;

   dtps_ram #(
      .WIDTH (NodeWidth),
      .DEPTH (NodeDepth)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr),
      .wr_addr (entry_wide[NodeAw-1:0]),
      .wr_data ({req_fixed_value, req_feature_select}),
      .rd_en   (node_issue),
      .rd_addr (node_idx_ff[NodeAw-1:0]),
      .rd_data (node_rd_data)
   );

   dtps_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (FeatDepth)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_wr),
      .wr_addr (entry_wide[FeatAw-1:0]),
      .wr_data (req_fixed_value),
      .rd_en   (s1_valid_ff && !fsel_out),
      .rd_addr (fsel_wide[FeatAw-1:0]),
      .rd_data (feat_rd_data)
   );

   // ---------------------------------------------------------------
   // Leaf scoring pass: issue, leaf read and mismatch count, best update
   logic [CountBits-1:0]              leaf_idx_ff, leaf_idx_in;
   logic                              leaf_issue;
   logic                              l1_valid_ff;
   logic [dtps_pkg::INDEX_BITS-1:0]   l1_idx_ff;
   logic                              l2_valid_ff;
   logic [dtps_pkg::INDEX_BITS-1:0]   l2_idx_ff;
   logic [dtps_pkg::LABEL_BITS-1:0]   l2_label_ff;
   logic [CountBits-1:0]              l2_score_ff;
   logic [LeafWidth-1:0]              leaf_rd_data;
   logic [dtps_pkg::PATH_BITS-1:0]    node_mask;
   logic [dtps_pkg::PATH_BITS-1:0]    leaf_members, leaf_left, mismatch;

   logic                              found_ff;
   logic [dtps_pkg::LABEL_BITS-1:0]   best_label_ff;
   logic [dtps_pkg::INDEX_BITS-1:0]   best_leaf_ff;
   logic [CountBits-1:0]              best_score_ff;
   logic                              best_take;

   assign leaf_issue  = cmd.leaf_run && leaf_idx_ff < leaves;
   assign leaf_idx_in = leaf_idx_ff + CountBits'(1);

   // only path bits of nodes in use count
   always_comb begin
      for (int i = 0; i < dtps_pkg::PATH_BITS; i++) begin
         node_mask[i] = nodes > CountBits'(i);
      end
   end

   assign leaf_members = leaf_rd_data[dtps_pkg::LABEL_BITS +: dtps_pkg::PATH_BITS];
   assign leaf_left    = leaf_rd_data[dtps_pkg::LABEL_BITS + dtps_pkg::PATH_BITS +:
                                      dtps_pkg::PATH_BITS];
   // indicator equal to the left bit means the path disagrees there
   assign mismatch = leaf_members & node_mask & ~(ind_ff ^ leaf_left);

   assign best_take = l2_valid_ff && (!found_ff || l2_score_ff < best_score_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_idx_ff <= '0;
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (cmd.start) begin
            leaf_idx_ff <= '0;
            found_ff    <= 1'b0;
         end else begin
            if (leaf_issue) begin
               leaf_idx_ff <= leaf_idx_in;
            end
            if (best_take) begin
               found_ff <= 1'b1;
            end
         end
         l1_valid_ff <= leaf_issue;
         l2_valid_ff <= l1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      l1_idx_ff   <= leaf_idx_ff[dtps_pkg::INDEX_BITS-1:0];
      l2_idx_ff   <= l1_idx_ff;
      l2_label_ff <= leaf_rd_data[dtps_pkg::LABEL_BITS-1:0];
      l2_score_ff <= CountBits'($countones(mismatch));
      if (cmd.start) begin
         best_label_ff <= '0;
         best_leaf_ff  <= '0;
         best_score_ff <= '0;
      end else if (best_take) begin
         best_label_ff <= l2_label_ff;
         best_leaf_ff  <= l2_idx_ff;
         best_score_ff <= l2_score_ff;
      end
   end

   assign status.leaf_done = leaf_idx_ff >= leaves && !l1_valid_ff && !l2_valid_ff;

   dtps_ram #(
      .WIDTH (LeafWidth),
      .DEPTH (LeafDepth)
   ) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_wr),
      .wr_addr (entry_wide[LeafAw-1:0]),
      .wr_data ({req_path_went_left, req_path_members, req_leaf_class}),
      .rd_en   (leaf_issue),
      .rd_addr (leaf_idx_ff[LeafAw-1:0]),
      .rd_data (leaf_rd_data)
   );

   // ---------------------------------------------------------------
   // Output register
   logic                              out_valid_ff;
   logic [dtps_pkg::LABEL_BITS-1:0]   out_label_ff;
   logic [dtps_pkg::INDEX_BITS-1:0]   out_leaf_ff;
   logic [CountBits-1:0]              out_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_label_ff <= best_label_ff;
         out_leaf_ff  <= best_leaf_ff;
         out_score_ff <= best_score_ff;
      end
   end

   assign status.out_free     = !out_valid_ff || rsp_taken;
   assign rsp_valid           = out_valid_ff;
   assign rsp_predicted_class = out_label_ff;
   assign rsp_winning_leaf    = out_leaf_ff;
   assign rsp_winning_score   = out_score_ff;

endmodule

/* rtl/core/decision_tree_path_sum_classifier_top.sv */
// Top level of the decision tree path sum classifier.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata entries, tuser kind, tlast last feature
//   rsp      out  rsp_tvalid/rsp_tready  tdata class, leaf, score
//   csr      in   csr_valid/csr_ready    csr_index, csr_data (count registers)
//
// Node, leaf and feature loads are accepted one beat per cycle while idle.
// A feature beat with tlast starts a classification: the node pass reads the node RAM
// then the feature RAM once per node, the leaf pass reads the leaf RAM once per leaf.
// Result goes to an output register; loads continue while it waits,
// but the next classification holds in its final state until the result is taken.
// Reset clears counts and control; table contents stay undefined until written.
module decision_tree_path_sum_classifier_top #(
   parameter int MAX_NODES    = dtps_pkg::MAX_NODES_DEFAULT,
   parameter int MAX_LEAVES   = dtps_pkg::MAX_LEAVES_DEFAULT,
   parameter int MAX_FEATURES = dtps_pkg::MAX_FEATURES_DEFAULT,
   parameter int VALUE_BITS   = dtps_pkg::VALUE_BITS_DEFAULT,
   localparam int ReqBits = dtps_pkg::INDEX_BITS + dtps_pkg::FSEL_BITS + VALUE_BITS
                            + dtps_pkg::LABEL_BITS + 2 * dtps_pkg::PATH_BITS,
   localparam int ReqDataBits = ((ReqBits + 7) / 8) * 8,
   localparam int RspBits = dtps_pkg::LABEL_BITS + dtps_pkg::INDEX_BITS
                            + dtps_pkg::COUNT_BITS,
   localparam int RspDataBits = ((RspBits + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request beats
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // entry_index, feature_select, fixed_value, leaf_class, path_members,
   // path_went_left, zero pad
   input  logic [ReqDataBits-1:0]               req_tdata,
   // req_type
   input  logic [dtps_pkg::KIND_BITS-1:0]       req_tuser,
   // last_feature
   input  logic                                 req_tlast,
   // result beats
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // predicted_class, winning_leaf, winning_score, zero pad
   output logic [RspDataBits-1:0]               rsp_tdata,
   // count register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dtps_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [dtps_pkg::COUNT_BITS-1:0]      csr_data
);

   localparam int FselLo  = dtps_pkg::INDEX_BITS;
   localparam int ValueLo = FselLo + dtps_pkg::FSEL_BITS;
   localparam int LabelLo = ValueLo + VALUE_BITS;
   localparam int MembLo  = LabelLo + dtps_pkg::LABEL_BITS;
   localparam int LeftLo  = MembLo + dtps_pkg::PATH_BITS;

   dtps_pkg::cmd_type    cmd;
   dtps_pkg::status_type status;

   logic [dtps_pkg::LABEL_BITS-1:0] rsp_predicted_class;
   logic [dtps_pkg::INDEX_BITS-1:0] rsp_winning_leaf;
   logic [dtps_pkg::COUNT_BITS-1:0] rsp_winning_score;

   // count registers are written any time
   assign csr_ready = 1'b1;

   dtps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_last   (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   dtps_dp #(
      .MAX_NODES    (MAX_NODES),
      .MAX_LEAVES   (MAX_LEAVES),
      .MAX_FEATURES (MAX_FEATURES),
      .VALUE_BITS   (VALUE_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_tuser),
      .req_entry_index     (req_tdata[dtps_pkg::INDEX_BITS-1:0]),
      .req_feature_select  (req_tdata[FselLo +: dtps_pkg::FSEL_BITS]),
      .req_fixed_value     ($signed(req_tdata[ValueLo +: VALUE_BITS])),
      .req_leaf_class      (req_tdata[LabelLo +: dtps_pkg::LABEL_BITS]),
      .req_path_members    (req_tdata[MembLo +: dtps_pkg::PATH_BITS]),
      .req_path_went_left  (req_tdata[LeftLo +: dtps_pkg::PATH_BITS]),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_tvalid),
      .rsp_taken           (rsp_tready),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_winning_leaf    (rsp_winning_leaf),
      .rsp_winning_score   (rsp_winning_score)
   );

   // pack the result beat, lowest field first
   assign rsp_tdata = RspDataBits'({rsp_winning_score, rsp_winning_leaf,
                                    rsp_predicted_class});

endmodule

/* tb/decision_tree_path_sum_classifier_top_test.sv */
// Self-checking testbench for the decision tree path sum classifier top level.
`timescale 1ns / 100ps

module decision_tree_path_sum_classifier_top_test;
   import dtps_pkg::*;

   localparam int VALUE_W      = VALUE_BITS_DEFAULT;
   localparam int NODE_SLOTS   = MAX_NODES_DEFAULT;
   localparam int LEAF_SLOTS   = MAX_LEAVES_DEFAULT;
   localparam int FEAT_SLOTS   = MAX_FEATURES_DEFAULT;
   localparam int REQ_BITS     = INDEX_BITS + FSEL_BITS + VALUE_W + LABEL_BITS + 2 * PATH_BITS;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((LABEL_BITS + INDEX_BITS + COUNT_BITS + 7) / 8) * 8;
   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_BEATS    = 155;
   localparam logic [KIND_BITS-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [INDEX_BITS-1:0] idx;
      logic [FSEL_BITS-1:0]  fsel;
      logic [VALUE_W-1:0]    value;
      logic [LABEL_BITS-1:0] label;
      logic [PATH_BITS-1:0]  members;
      logic [PATH_BITS-1:0]  lefts;
      logic                  last;
   } tree_req_type;

   typedef struct packed {
      logic [LABEL_BITS-1:0] label;
      logic [INDEX_BITS-1:0] leaf;
      logic [COUNT_BITS-1:0] score;
   } tree_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [KIND_BITS-1:0]  req_tuser  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [COUNT_BITS-1:0]   csr_data  = '0;

   decision_tree_path_sum_classifier_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Stimulus and expectation stores
   tree_req_type pending_beats[$];
   tree_rsp_type expected_classes[$];
   tree_req_type cur_beat;
   logic         req_taken = 1'b0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int err_count = 0;
   int req_beats = 0;
   int rsp_beats = 0;
   int csr_writes = 0;
   int stim_beats = 0;

   // Predictor copy of the tables and count registers
   logic [FSEL_BITS-1:0]     node_feat [NODE_SLOTS];
   logic signed [VALUE_W-1:0] node_thr [NODE_SLOTS];
   logic [LABEL_BITS-1:0]    leaf_lbl  [LEAF_SLOTS];
   logic [PATH_BITS-1:0]     leaf_mem  [LEAF_SLOTS];
   logic [PATH_BITS-1:0]     leaf_lft  [LEAF_SLOTS];
   logic signed [VALUE_W-1:0] feat_val [FEAT_SLOTS];
   logic [COUNT_BITS-1:0]    model_nodes = '0;
   logic [COUNT_BITS-1:0]    model_leaves = '0;

   // Generator view: which entries hold data, so nothing unwritten is ever read
   bit                   node_ok [NODE_SLOTS];
   logic [FSEL_BITS-1:0] node_fsel [NODE_SLOTS];
   bit                   leaf_ok [LEAF_SLOTS];
   bit                   feat_ok [FEAT_SLOTS];
   int                   gen_nodes = 0;
   int                   gen_leaves = 0;
   logic [VALUE_W-1:0]   recent_value = '0;

   // Hard-mode path sum: count path nodes whose indicator matches the left flag
   function automatic tree_rsp_type score_leaves();
      tree_rsp_type best;
      logic [PATH_BITS-1:0] ind;
      int nodes, leaves, score;
      bit found;
      best = '0;
      ind = '0;
      found = 0;
      nodes = (model_nodes > NODE_SLOTS) ? NODE_SLOTS : model_nodes;
      leaves = (model_leaves > LEAF_SLOTS) ? LEAF_SLOTS : model_leaves;
      for (int i = 0; i < nodes; i++)
         ind[i] = feat_val[node_feat[i]] > node_thr[i];
      for (int k = 0; k < leaves; k++) begin
         score = 0;
         for (int i = 0; i < nodes; i++)
            if (leaf_mem[k][i] && (ind[i] == leaf_lft[k][i]))
               score++;
         if (!found || score < best.score) begin
            found = 1;
            best.label = leaf_lbl[k];
            best.leaf = INDEX_BITS'(k);
            best.score = COUNT_BITS'(score);
         end
      end
      return best;
   endfunction

   task automatic load_or_classify(input tree_req_type r);
      case (r.kind)
         REQ_NODE: begin
            node_feat[r.idx] = r.fsel;
            node_thr[r.idx] = r.value;
         end
         REQ_LEAF: begin
            leaf_lbl[r.idx] = r.label;
            leaf_mem[r.idx] = r.members;
            leaf_lft[r.idx] = r.lefts;
         end
         REQ_FEATURE: begin
            if (r.idx < FEAT_SLOTS)
               feat_val[r.idx] = r.value;
            if (r.last)
               expected_classes = {expected_classes, score_leaves()};
         end
         default: ;
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return '0;
         3: return 16'hFFFF;
         4, 5: return recent_value;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic logic [PATH_BITS-1:0] rand_mask();
      case ($urandom_range(4))
         0: return $urandom & $urandom;
         1: return $urandom & $urandom & $urandom;
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic tree_req_type rand_entry(input logic [KIND_BITS-1:0] kind,
                                              input int idx);
      tree_req_type r;
      r.kind = kind;
      r.idx = INDEX_BITS'(idx);
      r.fsel = FSEL_BITS'($urandom);
      r.value = rand_value();
      r.label = LABEL_BITS'($urandom);
      r.members = rand_mask();
      r.lefts = $urandom;
      r.last = 1'b0;
      return r;
   endfunction

   function automatic tree_req_type mk(input logic [KIND_BITS-1:0] kind, input int idx,
                                      input int fsel, input logic [VALUE_W-1:0] value,
                                      input logic [LABEL_BITS-1:0] label,
                                      input logic [PATH_BITS-1:0] members,
                                      input logic [PATH_BITS-1:0] lefts, input bit last);
      tree_req_type r;
      r = '{kind, idx[INDEX_BITS-1:0], fsel[FSEL_BITS-1:0], value, label, members, lefts,
            last};
      return r;
   endfunction

   task automatic push_beat(input tree_req_type r);
      case (r.kind)
         REQ_NODE: begin
            node_ok[r.idx] = 1;
            node_fsel[r.idx] = r.fsel;
            recent_value = r.value;
         end
         REQ_LEAF: leaf_ok[r.idx] = 1;
         REQ_FEATURE: begin
            if (r.idx < FEAT_SLOTS)
               feat_ok[r.idx] = 1;
            recent_value = r.value;
         end
         default: ;
      endcase
      // every queued beat counts toward the phase size
      stim_beats++;
      pending_beats = {pending_beats, r};
   endtask

   // Fill every entry that the next classification will read
   task automatic make_ready();
      int nodes, leaves;
      nodes = (gen_nodes > NODE_SLOTS) ? NODE_SLOTS : gen_nodes;
      leaves = (gen_leaves > LEAF_SLOTS) ? LEAF_SLOTS : gen_leaves;
      for (int i = 0; i < nodes; i++)
         if (!node_ok[i])
            push_beat(rand_entry(REQ_NODE, i));
      for (int i = 0; i < nodes; i++)
         if (!feat_ok[node_fsel[i]])
            push_beat(rand_entry(REQ_FEATURE, node_fsel[i]));
      for (int k = 0; k < leaves; k++)
         if (!leaf_ok[k])
            push_beat(rand_entry(REQ_LEAF, k));
   endtask

   task automatic classify_now();
      tree_req_type r;
      make_ready();
      r = rand_entry(REQ_FEATURE, $urandom_range(FEAT_SLOTS - 1));
      r.last = 1'b1;
      push_beat(r);
   endtask

   task automatic random_beat();
      tree_req_type r;
      int pick;
      pick = $urandom_range(99);
      r = rand_entry(REQ_NODE, $urandom_range(NODE_SLOTS - 1));
      r.last = 1'($urandom);
      if (pick < 25) begin
         r.kind = REQ_NODE;
      end else if (pick < 50) begin
         r.kind = REQ_LEAF;
      end else if (pick < 95) begin
         r.kind = REQ_FEATURE;
         r.idx = INDEX_BITS'(($urandom_range(99) < 85) ? $urandom_range(FEAT_SLOTS - 1)
                                                       : $urandom_range(FEAT_SLOTS, 31));
         r.last = ($urandom_range(99) < 30);
         if (r.last)
            make_ready();
      end else begin
         r.kind = REQ_UNUSED;
      end
      push_beat(r);
   endtask

   // Wait until the block is idle, then let any work in flight finish
   task automatic wait_idle();
      @(posedge clock);
      while (pending_beats.size() != 0 || req_tvalid || expected_classes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [CSR_IDX_BITS-1:0] idx,
                              input logic [COUNT_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (idx == CSR_NODE_COUNT) begin
         model_nodes = value;
         gen_nodes = value;
      end else begin
         model_leaves = value;
         gen_leaves = value;
      end
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_counts(input int nodes, input int leaves);
      write_count(CSR_NODE_COUNT, COUNT_BITS'(nodes));
      write_count(CSR_LEAF_COUNT, COUNT_BITS'(leaves));
   endtask

   function automatic int pick_count();
      case ($urandom_range(9))
         0: return 0;
         1: return 32;
         2: return 63;
         3: return $urandom_range(33, 63);
         default: return $urandom_range(1, 31);
      endcase
   endfunction

   // Request driver: next beat after an accepted one, random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_beat = pending_beats.pop_front();
            req_tdata <= {{(REQ_DATA_W - REQ_BITS){1'b0}}, cur_beat.lefts, cur_beat.members,
                          cur_beat.label, cur_beat.value, cur_beat.fsel, cur_beat.idx};
            req_tuser <= cur_beat.kind;
            req_tlast <= cur_beat.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver stalls
   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Request monitor feeds the predictor
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         req_beats++;
         load_or_classify(cur_beat);
      end
   end

   // Result monitor: compare each beat with the oldest expectation
   always @(posedge clock) begin
      tree_rsp_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats++;
         got.label = rsp_tdata[7:0];
         got.leaf = rsp_tdata[12:8];
         got.score = rsp_tdata[18:13];
         if (expected_classes.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result beat class %0d leaf %0d score %0d",
                     $time, got.label, got.leaf, got.score);
         end else begin
            want = expected_classes.pop_front();
            if (got.label !== want.label) begin
               err_count++;
               $display("%0t: predicted_class expected %0d actual %0d",
                        $time, want.label, got.label);
            end
            if (got.leaf !== want.leaf) begin
               err_count++;
               $display("%0t: winning_leaf expected %0d actual %0d",
                        $time, want.leaf, got.leaf);
            end
            if (got.score !== want.score) begin
               err_count++;
               $display("%0t: winning_score expected %0d actual %0d",
                        $time, want.score, got.score);
            end
         end
      end
   end

   // Watchdog on cycles with no beat on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 26;
      recv_stall_pct = 50;

      // Directed: four nodes, three leaves, extremes and equal compares
      set_counts(4, 3);
      push_beat(mk(REQ_NODE, 0, 0, 16'h7FFF, 0, 0, 0, 0));
      push_beat(mk(REQ_NODE, 1, 1, 16'h8000, 0, 0, 0, 0));
      push_beat(mk(REQ_NODE, 2, 2, 16'h0000, 0, 0, 0, 0));
      push_beat(mk(REQ_NODE, 3, 15, 16'hFFFF, 0, 0, 0, 0));
      // leaf 0 has mask bits past node_count, leaves 1 and 2 tie
      push_beat(mk(REQ_LEAF, 0, 0, 0, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 0));
      push_beat(mk(REQ_LEAF, 1, 0, 0, 8'h00, 32'h0000_000F, 32'hFFFF_FFFF, 0));
      push_beat(mk(REQ_LEAF, 2, 0, 0, 8'hA5, 32'h0000_0005, 32'h0000_0001, 0));
      push_beat(mk(REQ_FEATURE, 0, 0, 16'h8000, 0, 0, 0, 0));
      push_beat(mk(REQ_FEATURE, 1, 0, 16'h7FFF, 0, 0, 0, 0));
      push_beat(mk(REQ_FEATURE, 2, 0, 16'h0000, 0, 0, 0, 0));
      push_beat(mk(REQ_FEATURE, 15, 0, 16'hFFFF, 0, 0, 0, 1));
      // unused kind with last set: no result
      push_beat(mk(REQ_UNUSED, 31, 15, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      // feature slot out of range: write dropped, classification still runs
      push_beat(mk(REQ_FEATURE, 20, 0, 16'h1234, 0, 0, 0, 0));
      push_beat(mk(REQ_FEATURE, 31, 0, 16'h7FFF, 0, 0, 0, 1));
      push_beat(mk(REQ_NODE, 2, 2, 16'hFFFF, 0, 0, 0, 0));
      push_beat(mk(REQ_FEATURE, 2, 0, 16'h0000, 0, 0, 0, 1));
      // last flag on table writes is ignored
      push_beat(mk(REQ_NODE, 31, 15, 16'h0000, 0, 0, 0, 1));
      push_beat(mk(REQ_LEAF, 31, 0, 0, 8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
      wait_idle();
      // no leaves
      set_counts(4, 0);
      push_beat(mk(REQ_FEATURE, 0, 0, 16'h0000, 0, 0, 0, 1));
      wait_idle();
      // no nodes: every leaf scores zero
      set_counts(0, 3);
      push_beat(mk(REQ_FEATURE, 1, 0, 16'h0001, 0, 0, 0, 1));
      wait_idle();
      // counts beyond table size act as full tables
      set_counts(63, 63);
      classify_now();
      wait_idle();
      set_counts(32, 32);
      classify_now();
      wait_idle();

      // Random phases with fresh counts; idle pattern changes by thirds
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph < RANDOM_PHASES / 3) begin
            send_idle_pct = 26;
            recv_stall_pct = 50;
         end else if (ph < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 50;
            recv_stall_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         set_counts(pick_count(), pick_count());
         stim_beats = 0;
         while (stim_beats < PHASE_BEATS)
            random_beat();
         wait_idle();
      end

      $display("Run covered %0d request beats, %0d checked classifications, %0d count writes.",
               req_beats, rsp_beats, csr_writes);
      $display("Counts from zero to overflow, ties, equal compares and dropped writes were hit.");
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
